// ----- hw/rtl/fdt_pkg.sv -----
// Shared types and constants for the fingerprint deduplication table.
// Used by the front queue, the search engine, the top level and the checker.
package fdt_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int HASH_W      = 32;
	localparam int SIZE_W      = 17;
	localparam int TOTAL_W     = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [SIZE_W-1:0] size;
	} fdt_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} fdt_state_t;

endpackage

// ----- hw/rtl/fdt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fdt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/fdt_front.sv -----
// Front end: takes items on the command port and holds them in a short queue.
// Depends on fdt_pkg.
module fdt_front import fdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] fingerprint,
	input  logic [SIZE_W-1:0] block_size,
	output logic              busy,
	output logic              item_valid,
	output fdt_item_t         item,
	input  logic              item_pop
);

	fdt_item_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                push;
	logic                pop;

	assign busy       = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign item_valid = (fill_q != '0);
	assign item       = entry_q[rd_ptr_q];
	assign push       = start && !busy;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{hash: fingerprint, size: block_size};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/fdt_search.sv -----
// Back end: linear search of the fingerprint RAM, table append and saturating totals.
// Depends on fdt_pkg and fdt_ram.
module fdt_search import fdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  fdt_item_t          item,
	output logic               item_pop,
	output logic               done,
	output logic               is_duplicate,
	output logic               was_inserted,
	output logic [TOTAL_W-1:0] hit_total,
	output logic [TOTAL_W-1:0] saved_total,
	output logic [CNT_W-1:0]   unique_total
);

	fdt_state_t         state_q, state_d;
	logic [ADDR_W-1:0]  idx_q, idx_d;
	logic               match_q, match_d;
	logic [HASH_W-1:0]  hash_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] hit_q;
	logic [TOTAL_W-1:0] saved_q;
	logic               done_q;
	logic               dup_q;
	logic               ins_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [HASH_W-1:0]  rd_data;
	logic               wr_en;
	logic               full;
	logic               last_entry;
	logic [TOTAL_W:0]   saved_sum;

	fdt_ram #(
		.WIDTH(HASH_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(hash_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign full       = (count_q == CNT_W'(TABLE_DEPTH));
	assign last_entry = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign saved_sum  = {1'b0, saved_q} + (TOTAL_W + 1)'(size_q);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		match_d  = match_q;
		item_pop = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					match_d  = 1'b0;
					idx_d    = '0;
					// With an empty table there is nothing to compare against.
					if (count_q == '0) begin
						state_d = ST_UPDATE;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// Read data on this cycle belongs to entry idx_q.
				if (rd_data == hash_q) begin
					match_d = 1'b1;
					state_d = ST_UPDATE;
				end else if (last_entry) begin
					state_d = ST_UPDATE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_UPDATE: begin
				wr_en   = !match_q && !full;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			hash_q <= item.hash;
			size_q <= item.size;
		end
		if (state_q == ST_UPDATE) begin
			dup_q <= match_q;
			ins_q <= !match_q && !full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			match_q <= 1'b0;
			count_q <= '0;
			hit_q   <= '0;
			saved_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			match_q <= match_d;
			done_q  <= (state_q == ST_UPDATE);
			if (state_q == ST_UPDATE) begin
				if (match_q) begin
					if (hit_q != '1) begin
						hit_q <= hit_q + 1'b1;
					end
					saved_q <= saved_sum[TOTAL_W] ? '1 : saved_sum[TOTAL_W-1:0];
				end else if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign done         = done_q;
	assign is_duplicate = dup_q;
	assign was_inserted = ins_q;
	assign hit_total    = hit_q;
	assign saved_total  = saved_q;
	assign unique_total = count_q;

endmodule

// ----- hw/rtl/fingerprint_dedup_table_core.sv -----
// Top level of the fingerprint deduplication table.
// Depends on fdt_pkg, fdt_front and fdt_search.

// An item is taken when start is high and busy is low; up to two items wait in the front
// queue while the search engine works. The engine reads one stored fingerprint per cycle
// from its single RAM read port until a match or the last entry held, then updates; on an
// empty table it skips the scan. The engine takes one item at a time. Each result is shown
// for one cycle with done high, in the cycle after the engine's update, and must be taken
// then: there is no way to hold it off. Results come in the order items were taken. busy
// rises only when the front queue is full.
module fingerprint_dedup_table_core import fdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [HASH_W-1:0]  fingerprint,
	input  logic [SIZE_W-1:0]  block_size,
	output logic               done,
	output logic               is_duplicate,
	output logic               was_inserted,
	output logic [TOTAL_W-1:0] hit_total,
	output logic [TOTAL_W-1:0] saved_total,
	output logic [CNT_W-1:0]   unique_total
);

	logic      item_valid;
	logic      item_pop;
	fdt_item_t item;

	fdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.fingerprint(fingerprint),
		.block_size (block_size),
		.busy       (busy),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	fdt_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.done        (done),
		.is_duplicate(is_duplicate),
		.was_inserted(was_inserted),
		.hit_total   (hit_total),
		.saved_total (saved_total),
		.unique_total(unique_total)
	);

endmodule

// ----- hw/rtl/fdt_checker.sv -----
// Port-level checker for the fingerprint deduplication table, bound to the top level.
// Depends on fdt_pkg.
module fdt_checker import fdt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               is_duplicate,
	input logic               was_inserted,
	input logic [TOTAL_W-1:0] hit_total,
	input logic [CNT_W-1:0]   unique_total
);

	logic [2:0]         pending_q;
	logic [TOTAL_W-1:0] last_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			last_hit_q <= '0;
		end else begin
			pending_q <= pending_q + 3'((start && !busy) ? 1 : 0) - 3'(done ? 1 : 0);
			if (done) begin
				last_hit_q <= hit_total;
			end
		end
	end

	// A result never appears without an item in flight.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pending_q != '0))
		else $error("result without an accepted item");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_duplicate && was_inserted))
		else $error("duplicate and insert flagged together");

	// The hit count only moves on a duplicate: at a non-duplicate result it must equal its value at the previous result.
	a_hit_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_duplicate) |-> (hit_total == last_hit_q))
		else $error("hit total changed without a duplicate");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (unique_total <= CNT_W'(TABLE_DEPTH)))
		else $error("unique total beyond table depth");

	// The engine always returns to idle after its update state, so strobes never touch.
	a_strobe_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

endmodule

bind fingerprint_dedup_table_core fdt_checker u_fdt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.is_duplicate(is_duplicate),
	.was_inserted(was_inserted),
	.hit_total   (hit_total),
	.unique_total(unique_total)
);
